>>> design/tcp_segment_checksum_checker_macros.svh
// ----------------------------------------------------------------------------
// TCP segment checksum checker assertion macros
// Clocked assertion helpers shared by the checker modules. Each macro uses
// the clk and rst_n of the module in which it is written.
// ----------------------------------------------------------------------------
`ifndef TCP_SEGMENT_CHECKSUM_CHECKER_MACROS_SVH
`define TCP_SEGMENT_CHECKSUM_CHECKER_MACROS_SVH

`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define TCSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tcsc assertion failed");
// When the antecedent holds, the consequent must hold in the next cycle.
`define TCSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcsc assertion failed");
`else
`define TCSC_ASSERT(lbl, prop)
`define TCSC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> design/tcsc_pkg.sv
// ----------------------------------------------------------------------------
// TCP segment checksum checker package
// Status codes, limits and the verdict record passed from the front end to
// the back end through the queue.
// ----------------------------------------------------------------------------
package tcsc_pkg;

  // Verdict status codes.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_SKIP   = 3'd1;
  localparam logic [2:0] ST_NOHDR  = 3'd2;
  localparam logic [2:0] ST_BADOFF = 3'd3;
  localparam logic [2:0] ST_SHORT  = 3'd4;
  localparam logic [2:0] ST_CSUM   = 3'd5;

  // Protocol and header limits.
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [15:0] MIN_HDR_BYTES = 16'd20;
  localparam logic [3:0]  MIN_OFFSET    = 4'd5;
  localparam logic [3:0]  OFFSET_WORD   = 4'd6;
  localparam logic [15:0] CSUM_GOOD     = 16'hFFFF;

  // Default error counter width.
  localparam int COUNT_WIDTH_DEF = 32;

  // Queue depth between front and back end.
  localparam int FIFO_DEPTH = 2;

  // One classified segment, waiting for the checksum compare and counting.
  typedef struct packed {
    logic        checked;    // TCP segment that went through the checks
    logic        skip_drop;  // drop flag for a skipped segment
    logic [2:0]  status;     // status before the checksum compare
    logic [15:0] seg_sum;    // folded sum of the segment words
    logic [15:0] pseudo_sum; // folded sum of the pseudo-header
  } tcsc_entry_t;

  // Queue fill flags.
  typedef struct packed {
    logic full;
    logic empty;
  } tcsc_fifo_stat_t;

endpackage

>>> design/tcsc_front.sv
// ----------------------------------------------------------------------------
// TCP segment checksum checker front end
// Accepts segment word beats, keeps the running one's-complement sum, the
// word index and the data offset, and on the last word classifies the
// segment and pushes a verdict record into the queue.
// ----------------------------------------------------------------------------
module tcsc_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_first_word,
  input  logic                    in_last_word,
  input  logic [15:0]             in_data_word,
  input  logic                    in_odd_tail,
  input  logic [31:0]             in_source_address,
  input  logic [31:0]             in_dest_address,
  input  logic [15:0]             in_ip_total_length,
  input  logic [3:0]              in_ip_header_words,
  input  logic [7:0]              in_ip_protocol,
  input  logic                    in_already_dropped,
  input  logic [15:0]             in_captured_length,
  input  tcsc_pkg::tcsc_fifo_stat_t fifo_stat,
  output logic                    push,
  output tcsc_pkg::tcsc_entry_t   push_data
);

  logic [15:0] sum_r, sum_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic [3:0]  off_r, off_nxt;

  logic [15:0] base_sum, base_idx, word_m, sum_add, idx_add, tlen;
  logic [3:0]  base_off, off_add;
  logic [16:0] add_raw;
  logic [18:0] ps_raw;
  logic [16:0] ps_fold;
  logic        accept;

  // A beat is taken whenever the queue has room.
  assign in_stall = fifo_stat.full;
  assign accept   = in_valid && !in_stall;

  // Running state for this beat, restarted on the first word.
  always_comb begin
    base_sum = in_first_word ? 16'd0 : sum_r;
    base_idx = in_first_word ? 16'd0 : idx_r;
    base_off = in_first_word ? 4'd0 : off_r;
    word_m   = (in_last_word && in_odd_tail) ? {in_data_word[15:8], 8'h00} : in_data_word;
    add_raw  = {1'b0, base_sum} + {1'b0, word_m};
    sum_add  = add_raw[15:0] + {15'd0, add_raw[16]};
    off_add  = (base_idx == {12'd0, tcsc_pkg::OFFSET_WORD}) ? word_m[15:12] : base_off;
    idx_add  = (base_idx == 16'hFFFF) ? base_idx : base_idx + 16'd1;
  end

  // The state clears after every verdict.
  always_comb begin
    sum_nxt = sum_r;
    idx_nxt = idx_r;
    off_nxt = off_r;
    if (accept) begin
      if (in_last_word) begin
        sum_nxt = 16'd0;
        idx_nxt = 16'd0;
        off_nxt = 4'd0;
      end else begin
        sum_nxt = sum_add;
        idx_nxt = idx_add;
        off_nxt = off_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= 16'd0;
      idx_r <= 16'd0;
      off_r <= 4'd0;
    end else begin
      sum_r <= sum_nxt;
      idx_r <= idx_nxt;
      off_r <= off_nxt;
    end
  end

  // Pseudo-header sum: addresses, TCP length and protocol, folded twice.
  always_comb begin
    tlen    = in_ip_total_length - {10'd0, in_ip_header_words, 2'b00};
    ps_raw  = 19'(in_source_address[31:16]) + 19'(in_source_address[15:0])
            + 19'(in_dest_address[31:16]) + 19'(in_dest_address[15:0])
            + 19'(tlen) + 19'(tcsc_pkg::PROTO_TCP);
    ps_fold = {1'b0, ps_raw[15:0]} + {14'd0, ps_raw[18:16]};
  end

  // Classification of the finished segment, checks in priority order.
  always_comb begin
    push_data            = '0;
    push_data.seg_sum    = sum_add;
    push_data.pseudo_sum = ps_fold[15:0] + {15'd0, ps_fold[16]};
    if (in_already_dropped) begin
      push_data.skip_drop = 1'b1;
      push_data.status    = tcsc_pkg::ST_SKIP;
    end else if (in_ip_protocol != tcsc_pkg::PROTO_TCP) begin
      push_data.status    = tcsc_pkg::ST_SKIP;
    end else begin
      push_data.checked = 1'b1;
      if (in_captured_length < tcsc_pkg::MIN_HDR_BYTES) begin
        push_data.status = tcsc_pkg::ST_NOHDR;
      end else if (off_add < tcsc_pkg::MIN_OFFSET) begin
        push_data.status = tcsc_pkg::ST_BADOFF;
      end else if (in_captured_length < {10'd0, off_add, 2'b00}) begin
        push_data.status = tcsc_pkg::ST_SHORT;
      end else begin
        push_data.status = tcsc_pkg::ST_OK;
      end
    end
  end

  assign push = accept && in_last_word;

endmodule

>>> design/tcsc_fifo.sv
// ----------------------------------------------------------------------------
// TCP segment checksum checker queue
// Short first-in first-out queue of verdict records between the front end
// and the back end.
// ----------------------------------------------------------------------------
module tcsc_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  tcsc_pkg::tcsc_entry_t     push_data,
  input  logic                      pop,
  output tcsc_pkg::tcsc_entry_t     head,
  output tcsc_pkg::tcsc_fifo_stat_t stat
);

  localparam int PtrW = $clog2(tcsc_pkg::FIFO_DEPTH);
  localparam int CntW = $clog2(tcsc_pkg::FIFO_DEPTH + 1);

  tcsc_pkg::tcsc_entry_t ent_r [tcsc_pkg::FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign stat.full  = (cnt_r == CntW'(tcsc_pkg::FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = ent_r[rd_ptr_r];

  // Pointer and fill count update with wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(tcsc_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(tcsc_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Record storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> design/tcsc_back.sv
// ----------------------------------------------------------------------------
// TCP segment checksum checker back end
// Pops verdict records, finishes the checksum compare, keeps the saturating
// error counter and holds the result beat in the output register.
// ----------------------------------------------------------------------------
`include "tcp_segment_checksum_checker_macros.svh"

module tcsc_back #(
  parameter int COUNT_WIDTH = tcsc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tcsc_pkg::tcsc_entry_t     head,
  input  tcsc_pkg::tcsc_fifo_stat_t fifo_stat,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_drop,
  output logic [2:0]                out_status,
  output logic [31:0]               out_error_total
);

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_drop_r;
  logic [2:0]             out_status_r;
  logic [31:0]            out_error_total_r;
  logic [COUNT_WIDTH-1:0] err_cnt_r, err_cnt_nxt;

  logic [16:0] csum_raw;
  logic [15:0] csum;
  logic [2:0]  status;
  logic        drop, bump;
  logic [31:0] err_total_nxt;

  // Pop when the output register is free or being drained.
  assign pop = !fifo_stat.empty && (!out_valid_r || !out_stall);

  // Final one's-complement add and verdict.
  always_comb begin
    csum_raw = {1'b0, head.seg_sum} + {1'b0, head.pseudo_sum};
    csum     = csum_raw[15:0] + {15'd0, csum_raw[16]};
    status   = head.status;
    if (head.checked && head.status == tcsc_pkg::ST_OK && csum != tcsc_pkg::CSUM_GOOD) begin
      status = tcsc_pkg::ST_CSUM;
    end
    bump = head.checked && (status != tcsc_pkg::ST_OK);
    drop = head.checked ? bump : head.skip_drop;
  end

  // Saturating error counter.
  always_comb begin
    err_cnt_nxt = err_cnt_r;
    if (pop && bump && (err_cnt_r != '1)) begin
      err_cnt_nxt = err_cnt_r + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
    end
  end

  // Reported count, clamped to all ones when it outgrows the port.
  generate
    if (COUNT_WIDTH > 32) begin : g_wide
      assign err_total_nxt = (|err_cnt_nxt[COUNT_WIDTH-1:32]) ? '1 : err_cnt_nxt[31:0];
    end else begin : g_narrow
      assign err_total_nxt = 32'(err_cnt_nxt);
    end
  endgenerate

  assign out_valid_nxt = pop || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      err_cnt_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      err_cnt_r   <= err_cnt_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (pop) begin
      out_drop_r        <= drop;
      out_status_r      <= status;
      out_error_total_r <= err_total_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drop        = out_drop_r;
  assign out_status      = out_status_r;
  assign out_error_total = out_error_total_r;

  // A record never overwrites a result beat that is still stalled.
  `TCSC_ASSERT(a_no_pop_over_held, !(pop && out_valid_r && out_stall))
  // The error counter never goes down.
  `TCSC_ASSERT_NEXT(a_cnt_monotonic, 1'b1, err_cnt_r >= $past(err_cnt_r))
  // The error counter only moves when a record is taken.
  `TCSC_ASSERT_NEXT(a_cnt_only_on_pop, !pop, err_cnt_r == $past(err_cnt_r))

endmodule

>>> design/tcp_segment_checksum_checker.sv
// A verdict beat reaches out_valid through the queue and the output register: the accepting
// edge of the last word writes the queue, then the record is popped into the output register
// once that register is free or draining. Throughput: one word per cycle while the queue has
// room, set by the single running-sum adder in the front end, and one verdict per cycle
// while out_stall is low; a two-entry queue separates the sides.
// Reset (rst_n low, synchronous) clears the sum, word index, offset, counter, queue and valid.
// ----------------------------------------------------------------------------
// TCP segment checksum checker
// Sums TCP segment words with the pseudo-header in one's complement and
// gives a drop verdict, status and error count for each segment.
// ----------------------------------------------------------------------------
module tcp_segment_checksum_checker #(
  parameter int COUNT_WIDTH = tcsc_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_first_word,
  input  logic        in_last_word,
  input  logic [15:0] in_data_word,
  input  logic        in_odd_tail,
  input  logic [31:0] in_source_address,
  input  logic [31:0] in_dest_address,
  input  logic [15:0] in_ip_total_length,
  input  logic [3:0]  in_ip_header_words,
  input  logic [7:0]  in_ip_protocol,
  input  logic        in_already_dropped,
  input  logic [15:0] in_captured_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_drop,
  output logic [2:0]  out_status,
  output logic [31:0] out_error_total
);

  tcsc_pkg::tcsc_entry_t     push_data, head;
  tcsc_pkg::tcsc_fifo_stat_t fifo_stat;
  logic                      push, pop;

  // Word intake and classification.
  tcsc_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_first_word      (in_first_word),
    .in_last_word       (in_last_word),
    .in_data_word       (in_data_word),
    .in_odd_tail        (in_odd_tail),
    .in_source_address  (in_source_address),
    .in_dest_address    (in_dest_address),
    .in_ip_total_length (in_ip_total_length),
    .in_ip_header_words (in_ip_header_words),
    .in_ip_protocol     (in_ip_protocol),
    .in_already_dropped (in_already_dropped),
    .in_captured_length (in_captured_length),
    .fifo_stat          (fifo_stat),
    .push               (push),
    .push_data          (push_data)
  );

  // Verdict queue.
  tcsc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (fifo_stat)
  );

  // Checksum compare, error counting and result output.
  tcsc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .fifo_stat       (fifo_stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drop        (out_drop),
    .out_status      (out_status),
    .out_error_total (out_error_total)
  );

endmodule

>>> verif/tcsc_verdict_monitor.sv
// ----------------------------------------------------------------------------
// TCP segment checksum verdict monitor
// Watches the word and verdict channels of the checksum checker. It keeps
// its own running sum, word position and header offset, works out the
// verdict due for each last word, and compares every verdict beat with the
// oldest one still owed.
// ----------------------------------------------------------------------------
module tcsc_verdict_monitor #(
  parameter int COUNT_WIDTH = tcsc_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_first_word,
  input  logic        in_last_word,
  input  logic [15:0] in_data_word,
  input  logic        in_odd_tail,
  input  logic [31:0] in_source_address,
  input  logic [31:0] in_dest_address,
  input  logic [15:0] in_ip_total_length,
  input  logic [3:0]  in_ip_header_words,
  input  logic [7:0]  in_ip_protocol,
  input  logic        in_already_dropped,
  input  logic [15:0] in_captured_length,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_drop,
  input  logic [2:0]  out_status,
  input  logic [31:0] out_error_total,
  output int          mismatch_count,
  output int          verdicts_pending
);

  localparam logic [63:0] TALLY_MAX =
    (COUNT_WIDTH >= 64) ? '1 : ((64'd1 << COUNT_WIDTH) - 64'd1);

  typedef struct packed {
    logic        drop;
    logic [2:0]  status;
    logic [31:0] error_total;
  } verdict_t;

  // Segment state as the block should hold it.
  logic [15:0] seg_sum;
  logic [15:0] word_pos;
  logic [3:0]  hdr_offset;
  logic [63:0] error_tally;
  verdict_t    expected_verdicts[$];

  // One's-complement add with end-around carry.
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // Fold one accepted word into the segment and, on a last word, queue the
  // verdict that it must produce.
  task automatic predict_verdict();
    logic [15:0] w;
    logic [15:0] tlen;
    logic [15:0] total;
    logic [2:0]  st;
    logic        drp;
    verdict_t    v;
    if (in_first_word) begin
      seg_sum = '0;
      word_pos = '0;
      hdr_offset = '0;
    end
    w = in_data_word;
    if (in_last_word && in_odd_tail) begin
      w[7:0] = 8'h00;
    end
    seg_sum = ones_add(seg_sum, w);
    if (word_pos == {12'd0, tcsc_pkg::OFFSET_WORD}) begin
      hdr_offset = w[15:12];
    end
    if (word_pos != 16'hFFFF) begin
      word_pos = word_pos + 16'd1;
    end
    if (!in_last_word) begin
      return;
    end

    // Skipped packets bypass every check and leave the counter alone.
    if (in_already_dropped) begin
      drp = 1'b1;
      st = tcsc_pkg::ST_SKIP;
    end else if (in_ip_protocol != tcsc_pkg::PROTO_TCP) begin
      drp = 1'b0;
      st = tcsc_pkg::ST_SKIP;
    end else begin
      if (in_captured_length < tcsc_pkg::MIN_HDR_BYTES) begin
        st = tcsc_pkg::ST_NOHDR;
      end else if (hdr_offset < tcsc_pkg::MIN_OFFSET) begin
        st = tcsc_pkg::ST_BADOFF;
      end else if (in_captured_length < {10'd0, hdr_offset, 2'b00}) begin
        st = tcsc_pkg::ST_SHORT;
      end else begin
        // Pseudo-header: both addresses, protocol and the TCP length, which
        // wraps when the IP header claims more bytes than the total.
        tlen = in_ip_total_length - {10'd0, in_ip_header_words, 2'b00};
        total = ones_add(seg_sum, in_source_address[31:16]);
        total = ones_add(total, in_source_address[15:0]);
        total = ones_add(total, in_dest_address[31:16]);
        total = ones_add(total, in_dest_address[15:0]);
        total = ones_add(total, tlen);
        total = ones_add(total, {8'd0, tcsc_pkg::PROTO_TCP});
        st = (total == tcsc_pkg::CSUM_GOOD) ? tcsc_pkg::ST_OK : tcsc_pkg::ST_CSUM;
      end
      drp = (st != tcsc_pkg::ST_OK);
      if (drp && error_tally < TALLY_MAX) begin
        error_tally = error_tally + 64'd1;
      end
    end

    v.drop = drp;
    v.status = st;
    v.error_total = (error_tally > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : error_tally[31:0];
    expected_verdicts.push_back(v);
    seg_sum = '0;
    word_pos = '0;
    hdr_offset = '0;
  endtask

  // Check one verdict beat against the oldest verdict owed.
  task automatic compare_verdict();
    verdict_t exp_v;
    if (expected_verdicts.size() == 0) begin
      $error("verdict beat with none owed: drop=%0d status=%0d error_total=%0d",
             out_drop, out_status, out_error_total);
      mismatch_count++;
      return;
    end
    exp_v = expected_verdicts.pop_front();
    if (out_drop !== exp_v.drop) begin
      $error("drop: expected %0d, got %0d", exp_v.drop, out_drop);
      mismatch_count++;
    end
    if (out_status !== exp_v.status) begin
      $error("status: expected %0d, got %0d", exp_v.status, out_status);
      mismatch_count++;
    end
    if (out_error_total !== exp_v.error_total) begin
      $error("error_total: expected %0d, got %0d", exp_v.error_total, out_error_total);
      mismatch_count++;
    end
  endtask

  // Both channels are sampled at the clock edge, before any drive changes.
  always @(posedge clk) begin
    if (!rst_n) begin
      seg_sum = '0;
      word_pos = '0;
      hdr_offset = '0;
      error_tally = '0;
      expected_verdicts.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        compare_verdict();
      end
      if (in_valid && !in_stall) begin
        predict_verdict();
      end
    end
    verdicts_pending = expected_verdicts.size();
  end

endmodule

>>> verif/tcp_segment_checksum_checker_tb.sv
// ----------------------------------------------------------------------------
// TCP segment checksum checker testbench
// Feeds the checker short directed segments for each verdict but a bad checksum, then random
// segments: well-formed ones with a correct checksum, mixed with
// every failure kind and stray words. Both sides idle at random, and the
// result side once holds off long enough to back the block up. The verdict
// monitor does the checking.
// ----------------------------------------------------------------------------
module tcp_segment_checksum_checker_tb;

  localparam int RANDOM_BEATS    = 900;
  localparam int CALM_BEATS      = 120;
  localparam int HOLD_OFF_CYCLES = 500;
  localparam int DRAIN_CYCLES    = 20;

  typedef enum {
    SEG_GOOD, SEG_BAD_SUM, SEG_NOT_TCP, SEG_DROPPED, SEG_NO_HEADER,
    SEG_BAD_OFFSET, SEG_SHORT, SEG_NO_WORD6, SEG_UNDERFLOW, SEG_NOISE
  } seg_kind_t;

  typedef struct packed {
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [15:0] total_len;
    logic [3:0]  hdr_words;
    logic [7:0]  proto;
    logic        dropped;
    logic [15:0] cap_len;
  } ip_facts_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_first_word = 1'b0;
  logic        in_last_word = 1'b0;
  logic [15:0] in_data_word = '0;
  logic        in_odd_tail = 1'b0;
  logic [31:0] in_source_address = '0;
  logic [31:0] in_dest_address = '0;
  logic [15:0] in_ip_total_length = '0;
  logic [3:0]  in_ip_header_words = '0;
  logic [7:0]  in_ip_protocol = '0;
  logic        in_already_dropped = 1'b0;
  logic [15:0] in_captured_length = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_drop;
  logic [2:0]  out_status;
  logic [31:0] out_error_total;
  int          mismatch_count;
  int          verdicts_pending;

  // Traffic shaping shared by the sender and the receiver.
  bit idle_mode = 1'b1;
  bit calm = 1'b0;
  bit hold_off_req = 1'b0;
  bit hold_off_done = 1'b0;

  // Segment under construction.
  logic [15:0] seg_words[$];
  ip_facts_t   seg_facts;
  logic        seg_odd;
  logic        seg_first;

  tcp_segment_checksum_checker dut (.*);
  tcsc_verdict_monitor u_monitor (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic ip_facts_t random_facts();
    ip_facts_t f;
    f.saddr = $urandom;
    f.daddr = $urandom;
    f.total_len = 16'($urandom);
    f.hdr_words = 4'($urandom);
    f.proto = 8'($urandom);
    f.dropped = 1'($urandom);
    f.cap_len = 16'($urandom);
    return f;
  endfunction

  // Write the checksum field (word 8) so that the segment plus pseudo-header
  // sums to all ones.
  function automatic void seal_checksum();
    logic [63:0] acc;
    logic [15:0] tlen;
    seg_words[8] = 16'h0000;
    acc = '0;
    foreach (seg_words[i]) begin
      if (i == seg_words.size() - 1 && seg_odd) begin
        acc = acc + {seg_words[i][15:8], 8'h00};
      end else begin
        acc = acc + seg_words[i];
      end
    end
    tlen = seg_facts.total_len - {10'd0, seg_facts.hdr_words, 2'b00};
    acc = acc + seg_facts.saddr[31:16] + seg_facts.saddr[15:0]
              + seg_facts.daddr[31:16] + seg_facts.daddr[15:0] + tlen
              + tcsc_pkg::PROTO_TCP;
    while (acc[63:16] != 0) begin
      acc = acc[15:0] + acc[63:16];
    end
    seg_words[8] = ~acc[15:0];
  endfunction

  // Build a segment of the given kind; n_words of zero picks a random size.
  function automatic void build_segment(input seg_kind_t kind, input int n_words);
    int n;
    int n_bytes;
    int offs;
    int flip;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 200) : $urandom_range(11, 40);
    if (n_words != 0) begin
      n = n_words;
    end
    if (kind == SEG_NO_WORD6) begin
      n = $urandom_range(1, 6);
    end
    seg_words.delete();
    repeat (n) seg_words.push_back(16'($urandom));
    seg_odd = 1'($urandom);
    seg_first = ($urandom_range(0, 9) != 0);
    n_bytes = 2 * n - seg_odd;
    offs = $urandom_range(5, (n_bytes / 4 > 15) ? 15 : n_bytes / 4);
    seg_facts.saddr = $urandom;
    seg_facts.daddr = $urandom;
    seg_facts.hdr_words = 4'($urandom_range(5, 15));
    seg_facts.total_len = 16'(4 * seg_facts.hdr_words + n_bytes);
    seg_facts.proto = tcsc_pkg::PROTO_TCP;
    seg_facts.dropped = 1'b0;
    seg_facts.cap_len = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(n_bytes, 65535))
                                                    : 16'(n_bytes);
    if (n_bytes > 65535) begin
      seg_facts.cap_len = 16'hFFFF;
    end
    case (kind)
      SEG_NOT_TCP: begin
        seg_facts.proto = 8'($urandom);
        if (seg_facts.proto == tcsc_pkg::PROTO_TCP) begin
          seg_facts.proto = 8'd17;
        end
      end
      SEG_DROPPED: begin
        seg_facts.dropped = 1'b1;
        seg_facts.proto = $urandom_range(0, 1) ? tcsc_pkg::PROTO_TCP : 8'($urandom);
      end
      SEG_NO_HEADER: seg_facts.cap_len = 16'($urandom_range(0, 19));
      SEG_BAD_OFFSET: offs = $urandom_range(0, 4);
      SEG_SHORT: begin
        offs = $urandom_range(6, 15);
        seg_facts.cap_len = 16'($urandom_range(20, offs * 4 - 1));
      end
      SEG_NO_WORD6: seg_facts.cap_len = 16'($urandom_range(20, 65535));
      SEG_UNDERFLOW: seg_facts.total_len = 16'($urandom_range(0, 4 * seg_facts.hdr_words - 1));
      default: ;
    endcase
    if (n > 8) begin
      seg_words[6][15:12] = offs[3:0];
      seal_checksum();
    end
    if (kind == SEG_BAD_SUM) begin
      flip = $urandom_range(9, n - 2);
      seg_words[flip] = seg_words[flip] ^ (16'd1 << $urandom_range(0, 15));
    end
  endfunction

  // Offer one word beat, after an optional idle burst, and hold it until
  // the block takes it.
  task automatic send_beat(input logic first, input logic last, input logic [15:0] word,
                           input logic odd, input ip_facts_t f);
    if (!calm && idle_mode && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_first_word <= first;
    in_last_word <= last;
    in_data_word <= word;
    in_odd_tail <= odd;
    in_source_address <= f.saddr;
    in_dest_address <= f.daddr;
    in_ip_total_length <= f.total_len;
    in_ip_header_words <= f.hdr_words;
    in_ip_protocol <= f.proto;
    in_already_dropped <= f.dropped;
    in_captured_length <= f.cap_len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // IP facts count only on the last word, so earlier words often carry junk.
  task automatic send_segment();
    int n;
    n = seg_words.size();
    for (int i = 0; i < n; i++) begin
      send_beat(i == 0 && seg_first, i == n - 1, seg_words[i],
                (i == n - 1) ? seg_odd : 1'($urandom),
                (i == n - 1 || $urandom_range(0, 1)) ? seg_facts : random_facts());
    end
  endtask

  function automatic seg_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return SEG_GOOD;
    if (r < 52) return SEG_BAD_SUM;
    if (r < 58) return SEG_NOT_TCP;
    if (r < 64) return SEG_DROPPED;
    if (r < 70) return SEG_NO_HEADER;
    if (r < 76) return SEG_BAD_OFFSET;
    if (r < 82) return SEG_SHORT;
    if (r < 87) return SEG_NO_WORD6;
    if (r < 93) return SEG_UNDERFLOW;
    return SEG_NOISE;
  endfunction

  // Result side: short stall bursts, quiet stretches, and one long hold-off.
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 63) == 0) begin
        repeat ($urandom_range(30, 120)) @(posedge clk);
      end
    end
  end

  // Word side and verdict.
  initial begin
    ip_facts_t f;
    seg_kind_t kind;
    int stim_beats;
    int n;
    stim_beats = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Single-word packets at the field extremes: already dropped, not TCP,
    // no room for a header, and a header whose offset word never came.
    f = '1;
    send_beat(1'b1, 1'b1, 16'hFFFF, 1'b1, f);
    f = '0;
    send_beat(1'b1, 1'b1, 16'h0000, 1'b0, f);
    f.proto = tcsc_pkg::PROTO_TCP;
    send_beat(1'b1, 1'b1, 16'h5A5A, 1'b0, f);
    f.cap_len = 16'hFFFF;
    send_beat(1'b1, 1'b1, 16'hA5A5, 1'b0, f);

    // Largest offset with too few captured bytes behind it.
    f = random_facts();
    f.proto = tcsc_pkg::PROTO_TCP;
    f.dropped = 1'b0;
    f.cap_len = 16'd59;
    for (int i = 0; i < 7; i++) begin
      send_beat(i == 0, i == 6, (i == 6) ? 16'hF000 : 16'($urandom), 1'($urandom), f);
    end

    // Good checksum with an odd tail, all-ones addresses and a TCP length
    // that wraps below zero.
    build_segment(SEG_GOOD, 11);
    seg_first = 1'b1;
    seg_odd = 1'b1;
    seg_facts.saddr = '1;
    seg_facts.daddr = '1;
    seg_facts.hdr_words = 4'hF;
    seg_facts.total_len = 16'd0;
    seg_facts.cap_len = 16'hFFFF;
    seal_checksum();
    send_segment();

    // Random segments.
    hold_off_req = 1'b1;
    while (stim_beats < RANDOM_BEATS) begin
      if (stim_beats >= RANDOM_BEATS - CALM_BEATS) begin
        calm = 1'b1;
      end
      idle_mode = ($urandom_range(0, 2) != 0);
      kind = pick_kind();
      if (kind == SEG_NOISE) begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
          f = random_facts();
          if ($urandom_range(0, 1)) begin
            f.proto = tcsc_pkg::PROTO_TCP;
          end
          if ($urandom_range(0, 3) != 0) begin
            f.dropped = 1'b0;
          end
          send_beat(1'($urandom), $urandom_range(0, 3) == 0, 16'($urandom), 1'($urandom), f);
        end
        stim_beats += n;
      end else begin
        build_segment(kind, 0);
        send_segment();
        stim_beats += seg_words.size();
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    wait (verdicts_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && verdicts_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
